// ===== rtl/rgb_to_hsv_pixel_assert.svh =====
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter: assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_PIXEL_ASSERT_SVH
`define RGB_TO_HSV_PIXEL_ASSERT_SVH

// Same-cycle implication check.
`define RTH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Next-cycle implication check.
`define RTH_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) cond |=> conseq) else $error(msg);

`endif

// ===== rtl/rth_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter: package
// Widths and word types shared by all modules, and the restoring division step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rth_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int FRAC_BITS    = 16;
  localparam int REM_BITS     = CHANNEL_BITS + 3;
  localparam int NUM_BITS     = REM_BITS + 1;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int DIV_STAGES   = FRAC_BITS;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } rth_in_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0]    hue;
    logic [FRAC_BITS-1:0]    saturation;
    logic [CHANNEL_BITS-1:0] value;
  } rth_out_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] value;
    logic [CHANNEL_BITS-1:0] chroma;
    logic [REM_BITS-1:0]     hue_num;
    logic                    black;
    logic                    gray;
  } rth_item_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] value;
    logic                    black;
    logic                    gray;
    logic [REM_BITS-1:0]     den_s;
    logic [REM_BITS-1:0]     den_h;
    logic [REM_BITS-1:0]     rem_s;
    logic [REM_BITS-1:0]     rem_h;
    logic [FRAC_BITS-1:0]    low_s;
    logic [FRAC_BITS-1:0]    q_s;
    logic [FRAC_BITS-1:0]    q_h;
  } rth_div_t;

  // One restoring division step: returns the quotient bit above the new remainder.
  function automatic logic [REM_BITS:0] div_step(input logic [REM_BITS-1:0] rem,
                                                 input logic [REM_BITS-1:0] den,
                                                 input logic                next_bit);
    logic [REM_BITS:0] trial;
    logic [REM_BITS:0] diff;
    trial = {rem, next_bit};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      return {1'b1, diff[REM_BITS-1:0]};
    end else begin
      return {1'b0, trial[REM_BITS-1:0]};
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rth_front.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter: front end
// Accepts a pixel, finds value, chroma and the hue numerator within one turn.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rth_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rth_pkg::rth_in_t   in_data,
  output logic                    item_valid,
  input  wire logic               item_ready,
  output rth_pkg::rth_item_t      item
);
  import rth_pkg::*;

  logic [CHANNEL_BITS-1:0] vmax;
  logic [CHANNEL_BITS-1:0] vmin;
  logic [CHANNEL_BITS-1:0] chroma;
  logic                    red_max;
  logic                    green_max;
  logic signed [NUM_BITS-1:0] rs, gs, bs, cs;
  logic signed [NUM_BITS-1:0] num_raw;
  logic signed [NUM_BITS-1:0] num_wrap;
  rth_item_t               item_next;

  always_comb begin
    red_max   = (in_data.red >= in_data.green) && (in_data.red >= in_data.blue);
    green_max = !red_max && (in_data.green >= in_data.blue);
    if (red_max) begin
      vmax = in_data.red;
    end else if (green_max) begin
      vmax = in_data.green;
    end else begin
      vmax = in_data.blue;
    end
    vmin = in_data.red;
    if (in_data.green < vmin) begin
      vmin = in_data.green;
    end
    if (in_data.blue < vmin) begin
      vmin = in_data.blue;
    end
    chroma = vmax - vmin;

    rs = signed'(NUM_BITS'(in_data.red));
    gs = signed'(NUM_BITS'(in_data.green));
    bs = signed'(NUM_BITS'(in_data.blue));
    cs = signed'(NUM_BITS'(chroma));
    if (red_max) begin
      num_raw = gs - bs;
    end else if (green_max) begin
      num_raw = bs - rs + (cs <<< 1);
    end else begin
      num_raw = rs - gs + (cs <<< 2);
    end
    if (num_raw < 0) begin
      num_wrap = num_raw + (cs <<< 2) + (cs <<< 1);
    end else begin
      num_wrap = num_raw;
    end

    item_next.value   = vmax;
    item_next.chroma  = chroma;
    item_next.hue_num = num_wrap[REM_BITS-1:0];
    item_next.black   = (vmax == '0);
    item_next.gray    = (chroma == '0);
  end

  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rth_queue.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter: decoupling queue
// Short register FIFO between the front end and the division pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_hsv_pixel_assert.svh"

module rth_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  wire rth_pkg::rth_item_t push_item,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output rth_pkg::rth_item_t      pop_item
);
  import rth_pkg::*;

  rth_item_t            slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 push;
  logic                 pop;

  assign push_ready = (count != (QPTR_BITS + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  `RTH_ASSERT(a_count_range, count <= (QPTR_BITS + 1)'(QUEUE_DEPTH), "queue count overflow")
  `RTH_ASSERT(a_ptr_match, (wr_ptr - rd_ptr) == count[QPTR_BITS-1:0], "queue pointers disagree with count")
  `RTH_ASSERT_NEXT(a_push_grows, push && !pop, count == $past(count) + 1'b1, "queue count did not grow")

endmodule

`default_nettype wire

// ===== rtl/rth_back.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter: division pipeline
// Two pipelined restoring dividers, one quotient bit per stage, and output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_hsv_pixel_assert.svh"

module rth_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire rth_pkg::rth_item_t item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rth_pkg::rth_out_t       out_data
);
  import rth_pkg::*;

  rth_div_t                   stg [DIV_STAGES];
  logic [DIV_STAGES-1:0]      vld;
  logic                       advance_en;
  logic [CHANNEL_BITS+FRAC_BITS-1:0] sat_num;
  rth_div_t                   stg_init;
  rth_div_t                   stg_last;
  rth_out_t                   out_next;

  function automatic rth_div_t div_advance(input rth_div_t cur);
    rth_div_t          nxt;
    logic [REM_BITS:0] s;
    logic [REM_BITS:0] h;
    nxt       = cur;
    s         = div_step(cur.rem_s, cur.den_s, cur.low_s[FRAC_BITS-1]);
    h         = div_step(cur.rem_h, cur.den_h, 1'b0);
    nxt.rem_s = s[REM_BITS-1:0];
    nxt.rem_h = h[REM_BITS-1:0];
    nxt.q_s   = {cur.q_s[FRAC_BITS-2:0], s[REM_BITS]};
    nxt.q_h   = {cur.q_h[FRAC_BITS-2:0], h[REM_BITS]};
    nxt.low_s = {cur.low_s[FRAC_BITS-2:0], 1'b0};
    return nxt;
  endfunction

  assign advance_en = !out_valid || out_ready;
  assign item_ready = advance_en;

  always_comb begin
    sat_num        = {item.chroma, {FRAC_BITS{1'b0}}}
                     - (CHANNEL_BITS + FRAC_BITS)'(item.chroma);
    stg_init.value = item.value;
    stg_init.black = item.black;
    stg_init.gray  = item.gray;
    stg_init.den_s = REM_BITS'(item.value);
    stg_init.den_h = (REM_BITS'(item.chroma) << 2) + (REM_BITS'(item.chroma) << 1);
    stg_init.rem_s = REM_BITS'(sat_num[CHANNEL_BITS+FRAC_BITS-1:FRAC_BITS]);
    stg_init.rem_h = item.hue_num;
    stg_init.low_s = sat_num[FRAC_BITS-1:0];
    stg_init.q_s   = '0;
    stg_init.q_h   = '0;

    stg_last            = div_advance(stg[DIV_STAGES-1]);
    out_next.hue        = stg_last.gray  ? '0 : stg_last.q_h;
    out_next.saturation = stg_last.black ? '0 : stg_last.q_s;
    out_next.value      = stg_last.value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (advance_en) begin
      vld       <= {vld[DIV_STAGES-2:0], item_valid};
      out_valid <= vld[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance_en) begin
      stg[0] <= stg_init;
      for (int i = 1; i < DIV_STAGES; i++) begin
        stg[i] <= div_advance(stg[i-1]);
      end
      out_data <= out_next;
    end
  end

  `RTH_ASSERT(a_gray_hue, (out_valid && out_data.saturation == '0) |-> (out_data.hue == '0), "nonzero hue with zero saturation")
  `RTH_ASSERT(a_black_sat, (out_valid && out_data.value == '0) |-> (out_data.saturation == '0), "nonzero saturation on a black pixel")
  `RTH_ASSERT_NEXT(a_stall_freeze, !advance_en, vld == $past(vld), "pipeline moved while stalled")

endmodule

`default_nettype wire

// ===== rtl/rgb_to_hsv_pixel.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter: top level
// Converts one RGB pixel word to an HSV word per clock while out_ready is high.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries a word of red, green and blue
// samples; output channel out_valid/out_ready carries hue, saturation and
// value. Hue is a 16-bit fraction of a turn, saturation a 16-bit fraction
// with all ones meaning 1.0, value the largest sample.
// Throughput is one word per cycle while out_ready is high. From acceptance
// to the output a word passes the front-end register, which loads at the
// accepting edge, then one queue slot, sixteen pipeline stages (fifteen
// restoring steps, one quotient bit each, hue and saturation in parallel)
// and the output register, which takes the last step.
// A four-entry queue sits between the front end and the division pipeline.
// While out_valid is high and out_ready low the pipeline freezes in place;
// the front end keeps taking words until the queue fills, then in_ready drops.
// Synchronous reset empties the queue and clears all valid flags; no
// configuration is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_pixel (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire rth_pkg::rth_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output rth_pkg::rth_out_t     out_data
);
  import rth_pkg::*;

  logic      front_valid;
  logic      front_ready;
  rth_item_t front_item;
  logic      queue_valid;
  logic      queue_ready;
  rth_item_t queue_item;

  rth_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  rth_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_item   (queue_item)
  );

  rth_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (queue_valid),
    .item_ready (queue_ready),
    .item       (queue_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire
